[rtl/core/cbrb_pkg.sv]
// shared types and constants of the counter based random block
`default_nettype none

package cbrb_pkg;

  localparam int unsigned Lanes = 4;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned Latency = 14;

  localparam logic [31:0] MulU = 32'd2718281829;
  localparam logic [31:0] MulV = 32'd3141592653;

  typedef logic [Lanes-1:0][31:0] lanes_t;

  localparam lanes_t Inc = {32'h9891A2B1, 32'hCC48D158, 32'h662468AC, 32'h33123456};

  typedef enum logic [1:0] {
    KeyW01 = 2'd0,
    KeyW23 = 2'd1,
    KeyW45 = 2'd2,
    KeyW67 = 2'd3
  } key_reg_e;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/core/cbrb_round.sv]
// one multiply-xor-rotate round over four lanes, four register stages
`default_nettype none

module cbrb_round import cbrb_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire ctl_t   ctl_i,
  input  wire lanes_t u_i,
  input  wire lanes_t v_i,
  output ctl_t        ctl_o,
  output lanes_t      u_o,
  output lanes_t      v_o
);

  ctl_t [3:0] ctl_q;
  lanes_t a1_d, b1_d, a1_q, b1_q;
  lanes_t b2_d, a2_q, b2_q;
  lanes_t a3_d, a3_q, b3_q;
  lanes_t a4_d, a4_q, b4_q;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    logic [63:0] prod_v;
    logic [63:0] prod_u;

    always_comb begin
      a1_d[i] = u_i[i] + Inc[i];
      b1_d[i] = (v_i[i] + a1_d[i]) ^ {a1_d[i][23:0], a1_d[i][31:24]};
      prod_v  = {32'd0, b1_q[i]} * {32'd0, MulV};
      b2_d[i] = prod_v[31:0];
      a3_d[i] = (a2_q[i] ^ (b2_q[i] << 9) ^ (b2_q[i] >> 23)) + b2_q[i];
      prod_u  = {32'd0, a3_q[i]} * {32'd0, MulU};
      a4_d[i] = prod_u[31:0];
      u_o[i]  = a4_q[i];
      v_o[i]  = (b4_q[i] ^ {a4_q[i][15:0], a4_q[i][31:16]}) + a4_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= {ctl_q[2:0], ctl_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d;
    b1_q <= b1_d;
    a2_q <= a1_q;
    b2_q <= b2_d;
    a3_q <= a3_d;
    b3_q <= b2_q;
    a4_q <= a4_d;
    b4_q <= b3_q;
  end

  assign ctl_o = ctl_q[3];

endmodule

`default_nettype wire

[rtl/core/counter_based_random_block_top.sv]
// top level of the counter based random block
//
// Takes one 64-bit block counter per clock cycle (busy_o stays low) and
// returns four 32-bit random words with done_o high for one cycle, once
// the start word has passed the pipeline: one stage forms the lane inputs
// from the key and counter, each of the three rounds takes four stages
// (two multiplies per lane, each followed by a register), and one output
// register. Results come out in order and cannot be held off. Key registers
// are written through the cfg port, which is always ready; write them only
// while no block is in flight. Indexes above three are ignored.
`default_nettype none

module counter_based_random_block_top import cbrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [63:0]        block_counter_i,
  input  wire logic               last_in_i,
  output logic                    done_o,
  output logic [31:0]             word_zero_o,
  output logic [31:0]             word_one_o,
  output logic [31:0]             word_two_o,
  output logic [31:0]             word_three_o,
  output logic                    last_out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  logic [3:0][63:0] key_q;
  logic [7:0][31:0] key_w;
  logic [31:0]      ctr_lo, ctr_hi;
  ctl_t             ctl0_d, ctl0_q, ctl1, ctl2, ctl3;
  lanes_t           u0_d, v0_d, u0_q, v0_q;
  lanes_t           u1, v1, v1p, u2, v2, v2p, u3, v3;
  lanes_t           word_q;
  logic             done_q, last_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i && cfg_index_i[CfgIdxW-1:2] == '0) begin
      case (key_reg_e'(cfg_index_i[1:0]))
        KeyW01:  key_q[0] <= cfg_data_i;
        KeyW23:  key_q[1] <= cfg_data_i;
        KeyW45:  key_q[2] <= cfg_data_i;
        KeyW67:  key_q[3] <= cfg_data_i;
        default: key_q    <= key_q;
      endcase
    end
  end

  assign ctr_lo = {block_counter_i[31:2], 2'b00};
  assign ctr_hi = block_counter_i[63:32];

  for (genvar k = 0; k < 8; k++) begin : g_key
    assign key_w[k] = key_q[k / 2][32 * (k % 2) +: 32];
  end

  for (genvar i = 0; i < Lanes; i++) begin : g_init
    assign u0_d[i] = key_w[i] ^ (ctr_lo + 32'(i)) ^ (ctr_hi + 32'(i));
    assign v0_d[i] = key_w[Lanes + i];
  end

  assign ctl0_d = '{valid: start_i && !busy_o, last: last_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl0_q <= ctl0_d;
      done_q <= ctl3.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    u0_q   <= u0_d;
    v0_q   <= v0_d;
    word_q <= v3;
    last_q <= ctl3.last;
  end

  cbrb_round u_round1 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl0_q),
    .u_i   (u0_q),
    .v_i   (v0_q),
    .ctl_o (ctl1),
    .u_o   (u1),
    .v_o   (v1)
  );

  // swap pairs
  assign v1p = {v1[2], v1[3], v1[0], v1[1]};

  cbrb_round u_round2 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl1),
    .u_i   (u1),
    .v_i   (v1p),
    .ctl_o (ctl2),
    .u_o   (u2),
    .v_o   (v2)
  );

  // swap halves
  assign v2p = {v2[1], v2[0], v2[3], v2[2]};

  cbrb_round u_round3 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl2),
    .u_i   (u2),
    .v_i   (v2p),
    .ctl_o (ctl3),
    .u_o   (u3),
    .v_o   (v3)
  );

  assign done_o       = done_q;
  assign word_zero_o  = word_q[0];
  assign word_one_o   = word_q[1];
  assign word_two_o   = word_q[2];
  assign word_three_o = word_q[3];
  assign last_out_o   = last_q;

endmodule

`default_nettype wire

[rtl/core/cbrb_chk.sv]
// port level checks of the counter based random block and their binding
`default_nettype none

module cbrb_chk import cbrb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic last_in_i,
  input wire logic done_o,
  input wire logic last_out_o
);

  // every taken word yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result missing after accepted word");

  // no result without a word taken before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without accepted word");

  // last flag travels with its word
  a_last_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> last_out_o == $past(last_in_i, Latency))
    else $error("last flag does not match its word");

endmodule

bind counter_based_random_block_top cbrb_chk u_cbrb_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .last_in_i (last_in_i),
  .done_o    (done_o),
  .last_out_o(last_out_o)
);

`default_nettype wire

[test/counter_based_random_block_top_tb.sv]
// self-checking testbench for the counter based random block, with its own keyed mixing predictor
`timescale 1ns / 100ps

module counter_based_random_block_top_tb;
  import cbrb_pkg::*;

  localparam int unsigned NumKeyRegs = 4;
  localparam logic [31:0] MixMulU = 32'd2718281829;
  localparam logic [31:0] MixMulV = 32'd3141592653;
  localparam logic [3:0][31:0] LaneInc = {
    32'h9891A2B1, 32'hCC48D158, 32'h662468AC, 32'h33123456
  };

  typedef struct packed {
    logic [63:0] counter;
    logic        last;
  } block_req_t;

  typedef struct packed {
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
    logic        last;
  } block_words_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [63:0] block_counter_i = '0;
  logic last_in_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic busy_o;
  logic done_o;
  logic [31:0] word_zero_o;
  logic [31:0] word_one_o;
  logic [31:0] word_two_o;
  logic [31:0] word_three_o;
  logic last_out_o;
  logic cfg_ready_o;

  logic [63:0] key_reg [NumKeyRegs];
  block_req_t counter_queue [$];
  block_words_t expected_words [$];
  int queued_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int fail_count = 0;
  int key_settings = 0;
  int idle_pct = 0;

  counter_based_random_block_top dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .block_counter_i,
    .last_in_i,
    .done_o,
    .word_zero_o,
    .word_one_o,
    .word_two_o,
    .word_three_o,
    .last_out_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic block_words_t mix_counter_block(input logic [63:0] counter,
                                                     input logic last);
    logic [31:0] key_word [8];
    logic [31:0] u [4];
    logic [31:0] v [4];
    logic [31:0] t [4];
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] lo;
    logic [31:0] hi;
    block_words_t res;
    for (int j = 0; j < NumKeyRegs; j++) begin
      key_word[2*j]   = key_reg[j][31:0];
      key_word[2*j+1] = key_reg[j][63:32];
    end
    lo = {counter[31:2], 2'b00};
    hi = counter[63:32];
    // no carry between the counter halves
    for (int i = 0; i < 4; i++) begin
      u[i] = key_word[i] ^ (lo + 32'(i)) ^ (hi + 32'(i));
      v[i] = key_word[4+i];
    end
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 4; i++) begin
        a = u[i] + LaneInc[i];
        b = v[i] + a;
        b ^= {a[23:0], a[31:24]};
        b = b * MixMulV;
        a ^= b << 9;
        a ^= b >> 23;
        a += b;
        a = a * MixMulU;
        b ^= {a[15:0], a[31:16]};
        b += a;
        u[i] = a;
        v[i] = b;
      end
      // lane swaps between rounds
      if (r == 0) begin
        t = '{v[1], v[0], v[3], v[2]};
        v = t;
      end else if (r == 1) begin
        t = '{v[2], v[3], v[0], v[1]};
        v = t;
      end
    end
    res.word_zero = v[0];
    res.word_one = v[1];
    res.word_two = v[2];
    res.word_three = v[3];
    res.last = last;
    return res;
  endfunction

  function automatic logic [63:0] random_counter();
    logic [63:0] c;
    case ($urandom_range(3))
      0: c = {$urandom, $urandom};
      1: c = {32'hFFFFFFFF - 32'($urandom_range(3)), $urandom};
      2: c = {$urandom, 32'hFFFFFFFF - 32'($urandom_range(7))};
      default: c = {32'($urandom_range(3)), 32'($urandom_range(255))};
    endcase
    return c;
  endfunction

  // driver: one word per accepted start
  always @(posedge clk_i) begin : drive_blk
    block_req_t req;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_words.push_back(mix_counter_block(block_counter_i, last_in_i));
        accepted_count++;
      end
      if (!start_i || !busy_o) begin
        if (counter_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req = counter_queue.pop_front();
          start_i <= 1'b1;
          block_counter_i <= req.counter;
          last_in_i <= req.last;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off
  always @(posedge clk_i) begin : check_blk
    block_words_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        result_count++;
        if (word_zero_o !== want.word_zero) begin
          $error("word_zero expected %h got %h", want.word_zero, word_zero_o);
          fail_count++;
        end
        if (word_one_o !== want.word_one) begin
          $error("word_one expected %h got %h", want.word_one, word_one_o);
          fail_count++;
        end
        if (word_two_o !== want.word_two) begin
          $error("word_two expected %h got %h", want.word_two, word_two_o);
          fail_count++;
        end
        if (word_three_o !== want.word_three) begin
          $error("word_three expected %h got %h", want.word_three, word_three_o);
          fail_count++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out expected %b got %b", want.last, last_out_o);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_block(input logic [63:0] counter, input logic last);
    block_req_t req;
    req.counter = counter;
    req.last = last;
    counter_queue.push_back(req);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count) @(posedge clk_i);
    for (int n = 0; n < 4 * Latency && expected_words.size() != 0; n++) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never came out", expected_words.size());
      fail_count++;
      expected_words.delete();
    end
  endtask

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumKeyRegs) key_reg[idx] = data;
  endtask

  // writes all four key registers plus one out of range index
  task automatic load_key(input logic [63:0] k01, input logic [63:0] k23,
                          input logic [63:0] k45, input logic [63:0] k67,
                          input logic [CfgIdxW-1:0] stray_idx);
    write_key(CfgIdxW'(KeyW01), k01);
    write_key(CfgIdxW'(KeyW23), k23);
    write_key(CfgIdxW'(KeyW45), k45);
    write_key(CfgIdxW'(KeyW67), k67);
    write_key(stray_idx, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    key_settings++;
  endtask

  initial begin
    for (int j = 0; j < NumKeyRegs; j++) key_reg[j] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, counter extremes and wrap of each half
    key_settings = 1;
    idle_pct = 12;
    queue_block(64'h0, 1'b0);
    queue_block(64'h1, 1'b1);
    queue_block(64'h2, 1'b0);
    queue_block(64'h3, 1'b1);
    queue_block(64'hFFFFFFFF_FFFFFFFF, 1'b1);
    queue_block(64'hFFFFFFFF_FFFFFFFC, 1'b0);
    queue_block(64'hFFFFFFFD_00000000, 1'b0);
    queue_block(64'hFFFFFFFE_7FFFFFFF, 1'b1);
    queue_block(64'h00000000_FFFFFFFC, 1'b0);
    queue_block(64'h80000000_80000000, 1'b1);
    queue_block(64'hAAAAAAAA_AAAAAAAA, 1'b0);
    queue_block(64'h55555555_55555555, 1'b1);
    wait_drained();

    load_key('1, '1, '1, '1, 8'hFF);
    queue_block(64'h0, 1'b1);
    queue_block(64'hFFFFFFFF_FFFFFFFF, 1'b0);
    queue_block(64'hFFFFFFFD_FFFFFFFE, 1'b1);
    queue_block(64'h12345678_9ABCDEF3, 1'b0);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      idle_pct = (k < 2) ? 12 : (k < 4) ? 68 : 0;
      if (k == 2) begin
        load_key('0, '0, '0, '0, 8'h04);
      end else begin
        load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, CfgIdxW'($urandom_range(255, NumKeyRegs)));
      end
      for (int n = 0; n < 305; n++) queue_block(random_counter(), $urandom_range(3) == 0);
      wait_drained();
    end

    $display("covered %0d blocks under %0d key settings, %0d results checked",
             accepted_count, key_settings, result_count);
    if (fail_count == 0) begin
      $display("PASS counter_based_random_block_top");
    end else begin
      $display("FAIL counter_based_random_block_top");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL counter_based_random_block_top");
    $finish;
  end

endmodule
